### hw/rtl/rgb_to_hsv_converter_defines.svh
// Assertion macros shared by the RGB to HSV converter RTL.
// Expects clk and rst_n in the scope of each use; empty under SYNTHESIS.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define RTHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition is followed by another in the next cycle
`define RTHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RTHC_ASSERT(lbl, prop, msg)
`define RTHC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/rthc_pkg.sv
// Shared constants, types and the divider step for the RGB to HSV converter.
// No dependencies; used by every module of the block by scoped names.
package rthc_pkg;

  // Hue resolution: 1/2^HUE_FRACTION_BITS degree
  localparam int HUE_FRACTION_BITS = 6;
  localparam int HUE_SECTOR        = 60 << HUE_FRACTION_BITS;
  localparam int HUE_CIRCLE        = 360 << HUE_FRACTION_BITS;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 16;

  // One quotient bit per cell; both quotients fit in SAT_W bits
  localparam int CELLS  = SAT_W;
  localparam int REM_W  = BYTE_W + CELLS;
  localparam int DSH_W  = BYTE_W + CELLS - 1;
  localparam int HC_W   = $clog2(HUE_CIRCLE) + 1;

  // Sector picked by the largest channel
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  // One restoring division lane
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DSH_W-1:0] dsh;
    logic [CELLS-1:0] quo;
  } lane_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic              valid;
    sector_t           sector;
    logic              neg;
    logic              grey;
    logic              black;
    logic [BYTE_W-1:0] bright;
    logic [BYTE_W-1:0] alpha;
    lane_t             hue_lane;
    lane_t             sat_lane;
  } word_t;

  // Retire one quotient bit and halve the shifted divisor
  function automatic lane_t div_step(input lane_t l);
    lane_t res;
    logic  fits;
    fits     = l.rem >= {1'b0, l.dsh};
    res.rem  = fits ? (l.rem - {1'b0, l.dsh}) : l.rem;
    res.dsh  = l.dsh >> 1;
    res.quo  = {l.quo[CELLS-2:0], fits};
    return res;
  endfunction

endpackage

### hw/rtl/rthc_front.sv
// Front cell: max/min search, sector pick and divider operand setup.
// Depends on rthc_pkg.
module rthc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rthc_pkg::BYTE_W-1:0] red,
  input  logic [rthc_pkg::BYTE_W-1:0] green,
  input  logic [rthc_pkg::BYTE_W-1:0] blue,
  input  logic [rthc_pkg::BYTE_W-1:0] alpha,
  output rthc_pkg::word_t            word_out
);

  logic [rthc_pkg::BYTE_W-1:0] hi;
  logic [rthc_pkg::BYTE_W-1:0] lo;
  logic [rthc_pkg::BYTE_W-1:0] chroma;
  logic [rthc_pkg::BYTE_W-1:0] plus;
  logic [rthc_pkg::BYTE_W-1:0] minus;
  logic [rthc_pkg::BYTE_W-1:0] diff;
  rthc_pkg::sector_t           sector;
  rthc_pkg::word_t             word_nxt;
  rthc_pkg::word_t             word_r;

  // Find largest and smallest channel
  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    chroma = hi - lo;
  end

  // Pick sector, ties go to red then green
  always_comb begin
    if (hi == red) begin
      sector = rthc_pkg::SECT_RED;
      plus   = green;
      minus  = blue;
    end else if (hi == green) begin
      sector = rthc_pkg::SECT_GREEN;
      plus   = blue;
      minus  = red;
    end else begin
      sector = rthc_pkg::SECT_BLUE;
      plus   = red;
      minus  = green;
    end
    diff = (plus >= minus) ? (plus - minus) : (minus - plus);
  end

  // Build the word: scaled dividends and divisors pre-shifted for the first cell
  always_comb begin
    word_nxt.valid        = start;
    word_nxt.sector       = sector;
    word_nxt.neg          = plus < minus;
    word_nxt.grey         = chroma == '0;
    word_nxt.black        = hi == '0;
    word_nxt.bright       = hi;
    word_nxt.alpha        = alpha;
    word_nxt.hue_lane.rem = rthc_pkg::REM_W'(rthc_pkg::HUE_SECTOR) * rthc_pkg::REM_W'(diff);
    word_nxt.hue_lane.dsh = {chroma, {(rthc_pkg::CELLS-1){1'b0}}};
    word_nxt.hue_lane.quo = '0;
    word_nxt.sat_lane.rem = {chroma, {rthc_pkg::SAT_W{1'b0}}} - rthc_pkg::REM_W'(chroma);
    word_nxt.sat_lane.dsh = {hi, {(rthc_pkg::CELLS-1){1'b0}}};
    word_nxt.sat_lane.quo = '0;
  end

  // Register the word; only the valid flag needs reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

### hw/rtl/rthc_div_cell.sv
// Divider cell: one quotient bit for the hue and saturation lanes per cycle.
// Depends on rthc_pkg and the assertion macros header.
`include "rgb_to_hsv_converter_defines.svh"

module rthc_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  rthc_pkg::word_t cell_in,
  output rthc_pkg::word_t cell_out
);

  rthc_pkg::word_t word_nxt;
  rthc_pkg::word_t word_r;

  // Advance both lanes by one step, carry the rest along
  always_comb begin
    word_nxt          = cell_in;
    word_nxt.hue_lane = rthc_pkg::div_step(cell_in.hue_lane);
    word_nxt.sat_lane = rthc_pkg::div_step(cell_in.sat_lane);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign cell_out = word_r;

  `RTHC_ASSERT_NEXT(a_cell_valid_moves, cell_in.valid, cell_out.valid, "cell dropped a word")

endmodule

### hw/rtl/rthc_back.sv
// Back cell: hue assembly with sector base and wrap, saturation forced to zero for black.
// Depends on rthc_pkg and the assertion macros header.
`include "rgb_to_hsv_converter_defines.svh"

module rthc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rthc_pkg::word_t             word_in,
  output logic                        out_valid,
  output logic [rthc_pkg::HUE_W-1:0]  hue,
  output logic [rthc_pkg::SAT_W-1:0]  sat,
  output logic [rthc_pkg::BYTE_W-1:0] bright,
  output logic [rthc_pkg::BYTE_W-1:0] alpha
);

  logic [rthc_pkg::HC_W-1:0]   mag;
  logic [rthc_pkg::HC_W-1:0]   base;
  logic [rthc_pkg::HC_W-1:0]   hue_calc;
  logic                        valid_r;
  logic [rthc_pkg::HUE_W-1:0]  hue_r;
  logic [rthc_pkg::SAT_W-1:0]  sat_r;
  logic [rthc_pkg::BYTE_W-1:0] bright_r;
  logic [rthc_pkg::BYTE_W-1:0] alpha_r;
  logic [rthc_pkg::HUE_W-1:0]  hue_nxt;
  logic [rthc_pkg::SAT_W-1:0]  sat_nxt;

  assign mag = rthc_pkg::HC_W'(word_in.hue_lane.quo);

  // Sector base angle
  always_comb begin
    case (word_in.sector)
      rthc_pkg::SECT_RED:   base = '0;
      rthc_pkg::SECT_GREEN: base = rthc_pkg::HC_W'(2 * rthc_pkg::HUE_SECTOR);
      rthc_pkg::SECT_BLUE:  base = rthc_pkg::HC_W'(4 * rthc_pkg::HUE_SECTOR);
      default:              base = '0;
    endcase
  end

  // Apply sign; grey gives hue zero, a negative red-sector hue wraps around the circle
  always_comb begin
    if (word_in.grey) begin
      hue_calc = '0;
    end else if (!word_in.neg) begin
      hue_calc = base + mag;
    end else if (word_in.sector == rthc_pkg::SECT_RED) begin
      hue_calc = (mag == '0) ? base : (rthc_pkg::HC_W'(rthc_pkg::HUE_CIRCLE) - mag);
    end else begin
      hue_calc = base - mag;
    end
    hue_nxt = rthc_pkg::HUE_W'(hue_calc);
    sat_nxt = word_in.black ? '0 : word_in.sat_lane.quo[rthc_pkg::SAT_W-1:0];
  end

  // Register the valid strobe in step with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= word_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    hue_r    <= hue_nxt;
    sat_r    <= sat_nxt;
    bright_r <= word_in.bright;
    alpha_r  <= word_in.alpha;
  end

  assign out_valid = valid_r;
  assign hue       = hue_r;
  assign sat       = sat_r;
  assign bright    = bright_r;
  assign alpha     = alpha_r;

  `RTHC_ASSERT(a_hue_in_circle, valid_r |-> hue_r < rthc_pkg::HUE_CIRCLE, "hue out of range")
  `RTHC_ASSERT(a_black_no_sat, valid_r && bright_r == '0 |-> sat_r == '0, "black pixel with saturation")
  `RTHC_ASSERT(a_grey_no_hue, valid_r && sat_r == '0 |-> hue_r == '0, "grey pixel with hue")

endmodule

### hw/rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter: front cell, a chain of 16 restoring divider cells, back cell.
// Each word is registered in the front cell, every divider cell and the back cell before out_valid rises.
// Throughput: one pixel per cycle; busy stays low and the receiver cannot stall.
// The divider chain sets the latency: one quotient bit per cell for both lanes.
// Reset (rst_n low, synchronous) clears all valid flags; words in flight are dropped.
module rgb_to_hsv_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [rthc_pkg::BYTE_W-1:0] in_red_in,
  input  logic [rthc_pkg::BYTE_W-1:0] in_green_in,
  input  logic [rthc_pkg::BYTE_W-1:0] in_blue_in,
  input  logic [rthc_pkg::BYTE_W-1:0] in_alpha_in,
  output logic                        out_valid,
  output logic [rthc_pkg::HUE_W-1:0]  out_hue_out,
  output logic [rthc_pkg::SAT_W-1:0]  out_saturation_out,
  output logic [rthc_pkg::BYTE_W-1:0] out_brightness_out,
  output logic [rthc_pkg::BYTE_W-1:0] out_alpha_out
);

  rthc_pkg::word_t chain_w [rthc_pkg::CELLS+1];

  // Fully pipelined: a word is taken in every cycle
  assign busy = 1'b0;

  rthc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .red      (in_red_in),
    .green    (in_green_in),
    .blue     (in_blue_in),
    .alpha    (in_alpha_in),
    .word_out (chain_w[0])
  );

  // Divider chain
  for (genvar i = 0; i < rthc_pkg::CELLS; i++) begin : g_cell
    rthc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain_w[i]),
      .cell_out (chain_w[i+1])
    );
  end

  rthc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_in   (chain_w[rthc_pkg::CELLS]),
    .out_valid (out_valid),
    .hue       (out_hue_out),
    .sat       (out_saturation_out),
    .bright    (out_brightness_out),
    .alpha     (out_alpha_out)
  );

endmodule
